// File: src/pds_pkg.sv
package pds_pkg;

    // Sequencer states of the divider search.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FOUT,
        ST_OD,
        ST_NR,
        ST_DIV,
        ST_CHECK,
        ST_DONE
    } pds_state_t;

    // Configuration register indexes.
    localparam logic REG_REF_FREQ = 1'b0;
    localparam logic REG_CEILING  = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [7:0]  REF_FREQ_RESET = 8'd25;
    localparam logic [11:0] CEILING_RESET  = 12'd1300;

    // Divider limits.
    localparam logic [4:0] NR_MAX = 5'd31;
    localparam logic [6:0] NF_MAX = 7'd127;
    localparam logic [1:0] OD_LAST = 2'd3;

    // Frequency windows in MHz.
    localparam logic [10:0] REF_WIN_LO = 11'd10;
    localparam logic [10:0] FREF_LIMIT = 11'd51;
    localparam logic [13:0] VCO_WIN_LO = 14'd800;
    localparam logic [13:0] VCO_WIN_HI = 14'd1600;
    localparam logic [12:0] OUT_WIN_LO = 13'd100;
    localparam logic [12:0] OUT_WIN_HI = 13'd1600;

    // Packed control word base pattern.
    localparam logic [2:0] WORD_BASE = 3'h7;

    // Restoring divider steps, one per dividend bit.
    localparam int          DIVIDEND_W = 16;
    localparam logic [3:0]  DIV_LAST   = 4'd15;

endpackage

// File: src/pll_divider_search.sv
// PLL divider search. A request carries a wanted output frequency in MHz. The
// block walks fout upward from that value to the ceiling register (and never
// past 1600 MHz, where nothing can match), and for each fout tries the output
// divider no = 1, 2, 4, 8, the input divider nr = 1..31 and looks up the
// smallest feedback divider nf with floor(fin*nf/(nr*no)) == fout. The first
// setting that meets the reference, VCO and output windows is packed into
// pll_word; when none is found the word is zero. One request is worked at a
// time and in_stall stays high until the result has been placed in the output
// register, which may still be waiting while the next request is accepted.
// Steps: the block accepts the request, passes over each fout that lies below
// 100 MHz, and for every other fout checks the fout and steps through the
// output dividers. For each no whose VCO frequency is in range it scans the
// input dividers, and for each nr whose reference frequency lies in 10..50 MHz
// it runs a 16-step restoring divide plus a check on the shared
// shift-and-subtract divider. When nothing matched it ends the walk, and it
// then delivers the result.
module pll_divider_search
    import pds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic        wr_index,
    input  logic [11:0] wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [11:0] target_freq,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [29:0] pll_word
);

    pds_state_t state_reg, state_next;

    logic [7:0]  ref_freq_reg;
    logic [11:0] ceiling_reg;

    // Search position.
    logic [12:0] fout_reg, fout_next;
    logic [1:0]  od_reg, od_next;
    logic [4:0]  nr_reg, nr_next;

    // Shared restoring divider: quotient shifts in where the dividend shifts out.
    logic [3:0]            cnt_reg, cnt_next;
    logic [7:0]            rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;

    logic [29:0] word_reg, word_next;
    logic        out_valid_reg, out_valid_next;
    logic [29:0] out_word_reg, out_word_next;

    // Datapath terms.
    logic [13:0]           fvco;
    logic                  fvco_ok;
    logic [10:0]           fref_lo;
    logic [10:0]           fref_hi;
    logic                  fref_ok;
    logic [DIVIDEND_W-1:0] dividend;
    logic [8:0]            trial;
    logic                  trial_ge;
    logic [16:0]           nf_full;
    logic [7:0]            excess;
    logic [7:0]            div_d;
    logic                  match;
    logic [6:0]            nf_code;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign pll_word  = out_word_reg;

    // VCO frequency for the current output divider.
    assign fvco    = {1'b0, fout_reg} << od_reg;
    assign fvco_ok = (fvco >= VCO_WIN_LO) && (fvco <= VCO_WIN_HI);

    // floor(fin/nr) in 10..50 is the same as 10*nr <= fin < 51*nr.
    assign fref_lo = 11'(nr_reg) * REF_WIN_LO;
    assign fref_hi = 11'(nr_reg) * FREF_LIMIT;
    assign fref_ok = (11'(ref_freq_reg) >= fref_lo) && (11'(ref_freq_reg) < fref_hi);

    // fout*nr*no, which fits 16 bits while fvco stays within its window.
    assign dividend = DIVIDEND_W'(fvco[10:0]) * DIVIDEND_W'(nr_reg);

    assign trial    = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign trial_ge = (trial >= {1'b0, ref_freq_reg});

    // The smallest nf is the rounded-up quotient. It reaches fout exactly when
    // the amount by which fin*nf overshoots fout*d stays below d.
    assign div_d   = 8'({3'b000, nr_reg} << od_reg);
    assign nf_full = {1'b0, quo_reg} + {16'd0, (rem_reg != 8'd0)};
    assign excess  = (rem_reg == 8'd0) ? 8'd0 : (ref_freq_reg - rem_reg);
    assign match   = (nf_full <= {10'd0, NF_MAX}) && (excess < div_d);

    // nf/2 - 1 wraps in seven bits, so nf of one packs as all ones.
    assign nf_code = {1'b0, nf_full[6:1]} - 7'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_freq_reg <= REF_FREQ_RESET;
            ceiling_reg  <= CEILING_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_REF_FREQ: ref_freq_reg <= wr_data[7:0];
                REG_CEILING:  ceiling_reg  <= wr_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fout_reg     <= fout_next;
        od_reg       <= od_next;
        nr_reg       <= nr_next;
        cnt_reg      <= cnt_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        word_reg     <= word_next;
        out_word_reg <= out_word_next;
    end

    always_comb
    begin
        logic next_nr;

        next_nr        = 1'b0;
        state_next     = state_reg;
        fout_next      = fout_reg;
        od_next        = od_reg;
        nr_next        = nr_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        word_next      = word_reg;
        out_word_next  = out_word_reg;
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    fout_next  = {1'b0, target_freq};
                    state_next = ST_FOUT;
                end
            end

            ST_FOUT:
            begin
                if ((fout_reg > {1'b0, ceiling_reg}) || (fout_reg > OUT_WIN_HI))
                begin
                    word_next  = '0;
                    state_next = ST_DONE;
                end
                else if (fout_reg < OUT_WIN_LO)
                begin
                    fout_next = fout_reg + 13'd1;
                end
                else
                begin
                    od_next    = 2'd0;
                    state_next = ST_OD;
                end
            end

            ST_OD:
            begin
                if (fvco_ok)
                begin
                    nr_next    = 5'd1;
                    state_next = ST_NR;
                end
                else if (od_reg == OD_LAST)
                begin
                    fout_next  = fout_reg + 13'd1;
                    state_next = ST_FOUT;
                end
                else
                begin
                    od_next = od_reg + 2'd1;
                end
            end

            ST_NR:
            begin
                if (fref_ok)
                begin
                    quo_next   = dividend;
                    rem_next   = 8'd0;
                    cnt_next   = 4'd0;
                    state_next = ST_DIV;
                end
                else
                begin
                    next_nr = 1'b1;
                end
            end

            ST_DIV:
            begin
                rem_next = trial_ge ? 8'(trial - {1'b0, ref_freq_reg}) : trial[7:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], trial_ge};
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                if (match)
                begin
                    word_next  = {od_reg, nf_code, nr_reg - 5'd1, 13'd0, WORD_BASE};
                    state_next = ST_DONE;
                end
                else
                begin
                    next_nr = 1'b1;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = word_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Step to the next input divider, or on to the next output divider
        // and fout once all input dividers are spent.
        if (next_nr)
        begin
            if (nr_reg != NR_MAX)
            begin
                nr_next    = nr_reg + 5'd1;
                state_next = ST_NR;
            end
            else if (od_reg != OD_LAST)
            begin
                od_next    = od_reg + 2'd1;
                state_next = ST_OD;
            end
            else
            begin
                fout_next  = fout_reg + 13'd1;
                state_next = ST_FOUT;
            end
        end
    end

endmodule

// File: src/pds_checker.sv
module pds_checker
    import pds_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [29:0] pll_word
);

    // A result waiting on a stalled receiver stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pll_word))
        else $error("stalled result changed");

    // A nonzero word always carries the base pattern and zero filler bits.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (pll_word != 30'd0) |-> (pll_word[2:0] == WORD_BASE)
            && (pll_word[15:3] == 13'd0))
        else $error("malformed control word");

    // An accepted request keeps the block busy for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("block free right after a request");

    // A new result only appears at the end of a search.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without a search");

endmodule

bind pll_divider_search pds_checker u_pds_checker (.*);

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import pds_pkg::*;

    // Longest search (in estimated cycles) that a random request may cause. Requests
    // whose search would run longer are drawn again, so the run stays short.
    localparam int unsigned COST_CAP = 30000;
    // Cycles without any accepted transfer before the run is declared hung.
    // The figure covers the longest allowed search, many times over.
    localparam int unsigned WATCHDOG_LIMIT = 250000;
    // Cycles to wait after the last result before a register write or the end.
    localparam int SETTLE_CYCLES = 20;
    // The result after which the receiver holds off, and for how long.
    localparam int HOLD_OFF_AT = 61;
    localparam int HOLD_OFF_CYCLES = 600;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        wr_en = 1'b0;
    logic        wr_index = REG_REF_FREQ;
    logic [11:0] wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [11:0] target_freq = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [29:0] pll_word;

    // Copy of the configuration registers as the block should hold them.
    logic [7:0]  ref_freq = REF_FREQ_RESET;
    logic [11:0] ceiling = CEILING_RESET;

    // Requests still to be offered, and control words still to come back.
    logic [11:0] pending_targets[$];
    logic [29:0] expected_words[$];

    int          requests_queued = 0;
    int          results_seen = 0;
    int          error_count = 0;
    int unsigned idle_cycles = 0;

    // Pacing state of the request side and of the result side.
    int          in_gap_left = 0;
    int          in_run = 0;
    bit          in_calm = 1'b0;
    int          out_stall_left = 0;
    int          out_run = 0;
    bit          out_calm = 1'b0;
    int unsigned drv_cycles;
    logic [29:0] drv_word;

    pll_divider_search i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .target_freq (target_freq),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pll_word    (pll_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Works out the control word for one request. The search walks fout upward
    // from the target, then the output divider, then the input divider, and for
    // each candidate takes the smallest feedback divider that could reach fout.
    // The first candidate inside all frequency windows wins. The estimated cycle
    // count follows the steps that the block documents and only serves to keep
    // random requests cheap.
    function automatic logic [29:0] predict_pll_word(input logic [11:0] target,
                                                     input logic [7:0] fin_mhz,
                                                     input logic [11:0] top_mhz,
                                                     output int unsigned cycles);
        int unsigned fout;
        int unsigned od;
        int unsigned no;
        int unsigned nr;
        int unsigned div;
        int unsigned nf;
        int unsigned fin;
        fin = fin_mhz;
        cycles = 3;
        for (fout = target; fout <= top_mhz; fout++)
        begin
            if (fout < OUT_WIN_LO)
            begin
                cycles += 1;
                continue;
            end
            // Nothing above the output window can ever match.
            if (fout > OUT_WIN_HI)
                break;
            cycles += 5;
            for (od = 0; od <= OD_LAST; od++)
            begin
                no = 1 << od;
                if (fout * no < VCO_WIN_LO || fout * no > VCO_WIN_HI)
                    continue;
                cycles += 31;
                for (nr = 1; nr <= NR_MAX; nr++)
                begin
                    if (fin / nr < REF_WIN_LO || fin / nr >= FREF_LIMIT)
                        continue;
                    cycles += 17;
                    div = nr * no;
                    nf = (fout * div + fin - 1) / fin;
                    if (nf < 1)
                        nf = 1;
                    if (nf <= NF_MAX && (fin * nf) / div == fout)
                    begin
                        // The feedback field holds nf/2 - 1, wrapped into 7 bits.
                        return 30'(WORD_BASE)
                            | (30'((nr - 1) & 32'h1f) << 16)
                            | (30'((nf / 2 - 1) & 32'h7f) << 21)
                            | (30'(od) << 28);
                    end
                end
            end
        end
        return '0;
    endfunction

    // Draws the wait before the next transfer of one side. The waits come in
    // runs: some runs never wait at all, the others draw a fresh random wait each.
    function automatic int draw_wait(inout int run_left, inout bit calm);
        if (run_left == 0)
        begin
            run_left = $urandom_range(3, 20);
            calm = ($urandom_range(0, 3) == 0);
        end
        run_left--;
        return calm ? 0 : $urandom_range(0, 12);
    endfunction

    // Request side. A request stays on the bus until it is taken; the expected
    // control word is worked out at the edge that takes it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            target_freq <= '0;
            in_gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                drv_word = predict_pll_word(target_freq, ref_freq, ceiling, drv_cycles);
                expected_words.push_back(drv_word);
            end
            if (!in_valid || !in_stall)
            begin
                if (in_gap_left != 0)
                begin
                    in_gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_targets.size() != 0)
                begin
                    in_valid <= 1'b1;
                    target_freq <= pending_targets.pop_front();
                    in_gap_left = draw_wait(in_run, in_calm);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result side. Every taken result is checked against the oldest expected
    // word; then the receiver stalls for a drawn number of cycles. Once in the
    // run it holds off for a long stretch so that the block backs up and has
    // to stall new requests.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_words.size() == 0)
                begin
                    $error("pll_word: no result expected, actual %h", pll_word);
                    error_count++;
                end
                else
                begin
                    drv_word = expected_words.pop_front();
                    if (pll_word !== drv_word)
                    begin
                        $error("pll_word: expected %h, actual %h", drv_word, pll_word);
                        error_count++;
                    end
                end
                out_stall_left = draw_wait(out_run, out_calm);
                if (results_seen == HOLD_OFF_AT)
                    out_stall_left = HOLD_OFF_CYCLES;
            end
            else if (out_stall_left != 0)
            begin
                out_stall_left--;
            end
            out_stall <= (out_stall_left != 0);
        end
    end

    // Ends the run if nothing moves for too long: no request, no result and
    // no register write.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic add_request(input logic [11:0] target);
        pending_targets.push_back(target);
        requests_queued++;
    endtask

    // Waits until every request has come back, then lets the block settle.
    task automatic wait_idle();
        while (results_seen < requests_queued)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [11:0] value);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= value;
        if (idx == REG_REF_FREQ)
            ref_freq = value[7:0];
        else
            ceiling = value;
    endtask

    // Writes both registers once the block has gone quiet.
    task automatic configure(input logic [11:0] fin_value, input logic [11:0] top_value);
        wait_idle();
        write_reg(REG_REF_FREQ, fin_value);
        write_reg(REG_CEILING, top_value);
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    // Random requests: most lie in the output window, where a setting is
    // usually found, some anywhere in the field, and some right around the
    // ceiling. Requests whose search would run too long are drawn again.
    task automatic add_random(input int count);
        int k;
        int tries;
        int pick;
        int t;
        int unsigned cost;
        for (k = 0; k < count; k++)
        begin
            tries = 0;
            do
            begin
                pick = $urandom_range(0, 19);
                if (pick < 14)
                    t = $urandom_range(100, 1600);
                else if (pick < 17)
                    t = $urandom_range(0, 4095);
                else
                    t = int'(ceiling) + $urandom_range(0, 16) - 8;
                if (t < 0)
                    t = 0;
                if (t > 4095)
                    t = 4095;
                void'(predict_pll_word(12'(t), ref_freq, ceiling, cost));
                tries++;
            end
            while (cost > COST_CAP && tries < 20);
            // The top of the field is either above the ceiling or above the
            // output window, so its search ends at once.
            if (cost > COST_CAP)
                t = 4095;
            add_request(12'(t));
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Reset configuration: field extremes, the window edges, the ceiling
        // itself and a request above the ceiling.
        add_request(12'd0);
        add_request(12'd99);
        add_request(12'd100);
        add_request(12'd1300);
        add_request(12'd1301);
        add_request(12'd4095);
        add_request(12'd777);
        add_random(15);

        // Fastest reference and the highest ceiling: requests above the
        // output window find nothing.
        configure(12'd255, 12'd4095);
        add_request(12'd1600);
        add_request(12'd1601);
        add_request(12'd2048);
        add_request(12'd150);
        add_random(15);

        // Zero reference, written through the upper data bits that the
        // register drops: no setting can match.
        configure(12'hf00, 12'd300);
        add_request(12'd0);
        add_request(12'd300);
        add_random(6);

        // Lowest nonzero reference and a zero ceiling: no fout above 0 passes the ceiling check.
        configure(12'd1, 12'd0);
        add_request(12'd0);
        add_request(12'd1);
        add_random(5);

        // A slow reference leaves bands of fout with no setting at all.
        configure(12'd10, 12'd1400);
        add_request(12'd159);
        add_request(12'd1280);
        add_request(12'd1271);
        add_random(10);

        // Random settings, with random values in the unused data bits.
        configure({4'($urandom), 8'($urandom_range(10, 255))},
                  12'($urandom_range(1000, 4095)));
        add_random(15);
        configure({4'($urandom), 8'($urandom_range(10, 255))},
                  12'($urandom_range(1000, 4095)));
        add_random(15);

        wait_idle();
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
